/* rtl/core/ryuv_pkg.sv */
// Shared constants for the RGB to planar YUV 4:2:0 converter.
// Port widths, register reset values, register index codes, parameter defaults.
// No dependencies.
`default_nettype none

package ryuv_pkg;

	localparam int MAX_DIMENSION_DEF       = 4096;
	localparam int COEFF_FRACTION_BITS_DEF = 16;

	localparam int DIM_REG_W     = 13;
	localparam int LUMA_ADDR_W   = 24;
	localparam int CHROMA_ADDR_W = 22;
	localparam int PIX_W         = 8;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 72;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/rgb_to_yuv420_planar.sv */
// Top level of the RGB to planar YUV 4:2:0 converter: frame position tracking,
// BT.601 fixed-point color conversion and the APB register block.
// Depends on ryuv_pkg.
//
// Usage:
//   RGB pixels enter on the s_t* stream in raster order, one word per pixel.
//   Every pixel leaves as one word on the m_t* stream: the luma byte with its
//   Y-plane address, and on even-column, even-row pixels inside the even-sized
//   area also U, V and their quarter-plane address (m_tuser high). m_tlast
//   marks the last pixel of the frame, after which the position wraps to zero.
//   Frame size is set through the APB port; a write to either register
//   returns the position to the frame start. Write only while the stream idles.
//   An accepted word passes from the input register to the result register
//   (three constant multiplies per plane between them), which drives m_tvalid.
//   Throughput: one pixel per cycle while m_tready stays high.
//   Reset: width 640, height 480, position zero, both stages empty.
//   Stall: while m_tready is low the result holds; an empty input stage takes
//   one more word, then s_tready drops until the receiver takes the result.
`default_nettype none

module rgb_to_yuv420_planar #(
	parameter int MAX_DIMENSION       = ryuv_pkg::MAX_DIMENSION_DEF,
	parameter int COEFF_FRACTION_BITS = ryuv_pkg::COEFF_FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ryuv_pkg::PADDR_W-1:0]       paddr,
	input  logic [ryuv_pkg::PDATA_W-1:0]       pwdata,
	output logic [ryuv_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// red [7:0], green [15:8], blue [23:16]
	input  logic [ryuv_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// luma [7:0], luma_address [31:8], chroma_u [39:32], chroma_v [47:40],
	// chroma_address [69:48], zero [71:70]
	output logic [ryuv_pkg::OUT_DATA_W-1:0]    m_tdata,
	// chroma_valid [0]
	output logic                               m_tuser,
	output logic                               m_tlast
);
	import ryuv_pkg::*;

	localparam int CNT_W = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int F      = COEFF_FRACTION_BITS;
	localparam int PROD_W = F + PIX_W;
	localparam int SUM_W  = F + 11;

	localparam longint Q_YR = ((longint'(299) << F) + 500) / 1000;
	localparam longint Q_YG = ((longint'(587) << F) + 500) / 1000;
	localparam longint Q_YB = ((longint'(114) << F) + 500) / 1000;
	localparam longint Q_UR = ((longint'(147) << F) + 500) / 1000;
	localparam longint Q_UG = ((longint'(289) << F) + 500) / 1000;
	localparam longint Q_UB = ((longint'(436) << F) + 500) / 1000;
	localparam longint Q_VR = ((longint'(615) << F) + 500) / 1000;
	localparam longint Q_VG = ((longint'(515) << F) + 500) / 1000;
	localparam longint Q_VB = ((longint'(100) << F) + 500) / 1000;

	localparam logic [SUM_W-1:0] HALF = {{(SUM_W-8){1'b0}}, 8'd128} << F;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
		if (32'(v) < 32'd2) return DIM_W'(2);
		else if (32'(v) > 32'(MAX_DIMENSION)) return DIM_W'(MAX_DIMENSION);
		else return DIM_W'(v);
	endfunction

	function automatic logic [PIX_W-1:0] to_byte(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] q;
		q = s >>> F;
		if (s[SUM_W-1]) return '0;
		else if (|q[SUM_W-1:PIX_W]) return 8'hFF;
		else return q[PIX_W-1:0];
	endfunction

	logic [DIM_REG_W-1:0]     image_width_q, image_height_q;
	logic [CNT_W-1:0]         col_q, row_q;
	logic [LUMA_ADDR_W-1:0]   luma_ptr_q;
	logic [CHROMA_ADDR_W-1:0] chroma_ptr_q;

	logic [DIM_W-1:0] w_dim, h_dim, w_even, h_even;
	logic             chroma_c, last_col_c, last_c;
	logic             cfg_wr, in_acc, adv;

	logic                     valid_s1;
	logic [PIX_W-1:0]         red_s1, green_s1, blue_s1;
	logic [LUMA_ADDR_W-1:0]   luma_addr_s1;
	logic [CHROMA_ADDR_W-1:0] chroma_addr_s1;
	logic                     chroma_s1, last_s1;

	logic                     valid_s2;
	logic [PIX_W-1:0]         luma_s2, u_s2, v_s2;
	logic [LUMA_ADDR_W-1:0]   luma_addr_s2;
	logic [CHROMA_ADDR_W-1:0] chroma_addr_s2;
	logic                     chroma_s2, last_s2;

	logic [PROD_W-1:0]       yr_p, yg_p, yb_p, ur_p, ug_p, ub_p, vr_p, vg_p, vb_p;
	logic signed [SUM_W-1:0] ys, us, vs;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[PADDR_W-1])
			REG_WIDTH:  prdata = PDATA_W'(image_width_q);
			REG_HEIGHT: prdata = PDATA_W'(image_height_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[PADDR_W-1])
				REG_WIDTH:  image_width_q  <= pwdata[DIM_REG_W-1:0];
				REG_HEIGHT: image_height_q <= pwdata[DIM_REG_W-1:0];
			endcase
		end
	end

	// frame position
	assign w_dim  = clamp_dim(image_width_q);
	assign h_dim  = clamp_dim(image_height_q);
	assign w_even = {w_dim[DIM_W-1:1], 1'b0};
	assign h_even = {h_dim[DIM_W-1:1], 1'b0};

	assign chroma_c   = !col_q[0] && !row_q[0] &&
		(32'(col_q) < 32'(w_even)) && (32'(row_q) < 32'(h_even));
	assign last_col_c = (32'(col_q) + 32'd1) >= 32'(w_dim);
	assign last_c     = last_col_c && ((32'(row_q) + 32'd1) >= 32'(h_dim));

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			luma_ptr_q   <= '0;
			chroma_ptr_q <= '0;
		end else if (cfg_wr || (in_acc && last_c)) begin
			col_q        <= '0;
			row_q        <= '0;
			luma_ptr_q   <= '0;
			chroma_ptr_q <= '0;
		end else if (in_acc) begin
			luma_ptr_q <= luma_ptr_q + 1'b1;
			if (chroma_c) chroma_ptr_q <= chroma_ptr_q + 1'b1;
			if (last_col_c) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (s_tready) valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			red_s1         <= s_tdata[7:0];
			green_s1       <= s_tdata[15:8];
			blue_s1        <= s_tdata[23:16];
			luma_addr_s1   <= luma_ptr_q;
			chroma_addr_s1 <= chroma_ptr_q;
			chroma_s1      <= chroma_c;
			last_s1        <= last_c;
		end
	end

	// color conversion
	assign yr_p = {{F{1'b0}}, red_s1}   * PROD_W'(Q_YR);
	assign yg_p = {{F{1'b0}}, green_s1} * PROD_W'(Q_YG);
	assign yb_p = {{F{1'b0}}, blue_s1}  * PROD_W'(Q_YB);
	assign ur_p = {{F{1'b0}}, red_s1}   * PROD_W'(Q_UR);
	assign ug_p = {{F{1'b0}}, green_s1} * PROD_W'(Q_UG);
	assign ub_p = {{F{1'b0}}, blue_s1}  * PROD_W'(Q_UB);
	assign vr_p = {{F{1'b0}}, red_s1}   * PROD_W'(Q_VR);
	assign vg_p = {{F{1'b0}}, green_s1} * PROD_W'(Q_VG);
	assign vb_p = {{F{1'b0}}, blue_s1}  * PROD_W'(Q_VB);

	assign ys = SUM_W'(yr_p) + SUM_W'(yg_p) + SUM_W'(yb_p);
	assign us = SUM_W'(ub_p) - SUM_W'(ur_p) - SUM_W'(ug_p) + HALF;
	assign vs = SUM_W'(vr_p) - SUM_W'(vg_p) - SUM_W'(vb_p) + HALF;

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (adv) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			luma_s2        <= to_byte(ys);
			u_s2           <= chroma_s1 ? to_byte(us) : '0;
			v_s2           <= chroma_s1 ? to_byte(vs) : '0;
			luma_addr_s2   <= luma_addr_s1;
			chroma_addr_s2 <= chroma_s1 ? chroma_addr_s1 : '0;
			chroma_s2      <= chroma_s1;
			last_s2        <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, chroma_addr_s2, v_s2, u_s2, luma_addr_s2, luma_s2};
	assign m_tuser  = chroma_s2;
	assign m_tlast  = last_s2;

endmodule

`default_nettype wire

/* rtl/core/ryuv_checker.sv */
// Port-level checks on the result stream of rgb_to_yuv420_planar,
// bound to the top level. Depends on ryuv_pkg.
`default_nettype none

module ryuv_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ryuv_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            m_tuser,
	input logic                            m_tlast
);
	import ryuv_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("result word changed while stalled");

	a_no_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[69:32] == '0)
		else $error("chroma fields not zero on luma-only word");

	a_chroma_even_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[8])
		else $error("chroma word at odd luma address");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:70] == '0)
		else $error("padding bits of result word not zero");

endmodule

bind rgb_to_yuv420_planar ryuv_checker u_ryuv_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_yuv420_planar: streams RGB pixels through the
// block under several frame sizes and idle patterns and checks every output word
// against a built-in predictor. Depends on ryuv_pkg and the rgb_to_yuv420_planar RTL.

module testbench;

	import ryuv_pkg::*;

	localparam int     FRAC_BITS   = COEFF_FRACTION_BITS_DEF;
	localparam int     MAX_DIM     = MAX_DIMENSION_DEF;
	localparam int     STALL_LIMIT = 3000;
	localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
	localparam longint KY_R = (299 * ONE_Q + 500) / 1000;
	localparam longint KY_G = (587 * ONE_Q + 500) / 1000;
	localparam longint KY_B = (114 * ONE_Q + 500) / 1000;
	localparam longint KU_R = (147 * ONE_Q + 500) / 1000;
	localparam longint KU_G = (289 * ONE_Q + 500) / 1000;
	localparam longint KU_B = (436 * ONE_Q + 500) / 1000;
	localparam longint KV_R = (615 * ONE_Q + 500) / 1000;
	localparam longint KV_G = (515 * ONE_Q + 500) / 1000;
	localparam longint KV_B = (100 * ONE_Q + 500) / 1000;
	localparam longint CHROMA_BIAS = 128 * ONE_Q;

	typedef struct {
		logic [7:0]               luma;
		logic [LUMA_ADDR_W-1:0]   luma_addr;
		logic                     chroma_valid;
		logic [7:0]               u;
		logic [7:0]               v;
		logic [CHROMA_ADDR_W-1:0] chroma_addr;
		logic                     last;
	} yuv_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [PDATA_W-1:0]    pwdata = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	logic [IN_DATA_W-1:0] rgb_backlog[$];
	yuv_word_t            yuv_pending[$];

	logic [DIM_REG_W-1:0]     cfg_width = WIDTH_RESET;
	logic [DIM_REG_W-1:0]     cfg_height = HEIGHT_RESET;
	int                       col_pos = 0;
	int                       row_pos = 0;
	logic [LUMA_ADDR_W-1:0]   luma_ptr = '0;
	logic [CHROMA_ADDR_W-1:0] chroma_ptr = '0;

	int gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int pixels_in = 0;
	int words_out = 0;
	int chroma_seen = 0;
	int frames_seen = 0;
	int sizes_run = 0;
	int quiet_cycles = 0;

	rgb_to_yuv420_planar uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int fit_dim(input logic [DIM_REG_W-1:0] v);
		if (v < 2)
			return 2;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	function automatic logic [7:0] sat_byte(input longint s);
		longint q;
		if (s < 0)
			return 8'd0;
		q = s >>> FRAC_BITS;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = 0;
		luma_ptr = '0;
		chroma_ptr = '0;
	endfunction

	function automatic yuv_word_t convert_pixel(input logic [IN_DATA_W-1:0] rgb);
		yuv_word_t w;
		longint    rr, gg, bb, ys, us, vs;
		int        wd, ht;
		logic      has_chroma, end_row, end_frame;
		rr = rgb[7:0];
		gg = rgb[15:8];
		bb = rgb[23:16];
		wd = fit_dim(cfg_width);
		ht = fit_dim(cfg_height);
		ys = KY_R * rr + KY_G * gg + KY_B * bb;
		us = -KU_R * rr - KU_G * gg + KU_B * bb + CHROMA_BIAS;
		vs = KV_R * rr - KV_G * gg - KV_B * bb + CHROMA_BIAS;
		has_chroma = (col_pos % 2 == 0) && (row_pos % 2 == 0) &&
			(col_pos < (wd & ~1)) && (row_pos < (ht & ~1));
		end_row = (col_pos + 1 >= wd);
		end_frame = end_row && (row_pos + 1 >= ht);
		w.luma = sat_byte(ys);
		w.luma_addr = luma_ptr;
		w.chroma_valid = has_chroma;
		w.u = has_chroma ? sat_byte(us) : 8'd0;
		w.v = has_chroma ? sat_byte(vs) : 8'd0;
		w.chroma_addr = has_chroma ? chroma_ptr : '0;
		w.last = end_frame;
		if (end_frame) begin
			restart_frame();
		end else begin
			luma_ptr = luma_ptr + 1'b1;
			if (has_chroma)
				chroma_ptr = chroma_ptr + 1'b1;
			if (end_row) begin
				col_pos = 0;
				row_pos = row_pos + 1;
			end else begin
				col_pos = col_pos + 1;
			end
		end
		return w;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch in %s at output word %0d: got %0h, want %0h",
				field, words_out, got, want);
	endtask

	// Sender: hold the word until taken, predict on acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				yuv_pending.push_back(convert_pixel(s_tdata));
				pixels_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (rgb_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= rgb_backlog.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall at random, compare each word with the oldest prediction.
	always @(posedge clk) begin
		yuv_word_t want;
		m_tready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			words_out++;
			if (m_tuser)
				chroma_seen++;
			if (m_tlast)
				frames_seen++;
			if (yuv_pending.size() == 0) begin
				report_mismatch("word with nothing pending", m_tdata[31:0], 32'd0);
			end else begin
				want = yuv_pending.pop_front();
				if (m_tdata[7:0] !== want.luma)
					report_mismatch("luma", m_tdata[7:0], want.luma);
				if (m_tdata[31:8] !== want.luma_addr)
					report_mismatch("luma_address", m_tdata[31:8], want.luma_addr);
				if (m_tuser !== want.chroma_valid)
					report_mismatch("chroma_valid", m_tuser, want.chroma_valid);
				if (m_tdata[39:32] !== want.u)
					report_mismatch("chroma_u", m_tdata[39:32], want.u);
				if (m_tdata[47:40] !== want.v)
					report_mismatch("chroma_v", m_tdata[47:40], want.v);
				if (m_tdata[69:48] !== want.chroma_addr)
					report_mismatch("chroma_address", m_tdata[69:48], want.chroma_addr);
				if (m_tlast !== want.last)
					report_mismatch("frame_last", m_tlast, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("rgb_to_yuv420_planar verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_write(input logic sel, input int value);
		logic [PDATA_W-1:0] data;
		data = ($urandom() & ~32'h1FFF) | (value & 32'h1FFF);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == REG_WIDTH)
			cfg_width = data[DIM_REG_W-1:0];
		else
			cfg_height = data[DIM_REG_W-1:0];
		restart_frame();
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_check(input logic sel);
		logic [PDATA_W-1:0] want;
		want = (sel == REG_WIDTH) ? PDATA_W'(cfg_width) : PDATA_W'(cfg_height);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch(sel == REG_WIDTH ? "image_width readback" :
				"image_height readback", prdata, want);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (rgb_backlog.size() != 0 || s_tvalid || yuv_pending.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_size(input int wd, input int ht);
		apb_write(REG_WIDTH, wd);
		apb_write(REG_HEIGHT, ht);
		apb_check(REG_WIDTH);
		apb_check(REG_HEIGHT);
		sizes_run++;
		@(negedge clk);
	endtask

	task automatic set_idle(input int mode);
		case (mode % 4)
			0: begin gap_pct = 0; stall_pct = 0; end
			1: begin gap_pct = 82; stall_pct = 0; end
			2: begin gap_pct = 0; stall_pct = 82; end
			default: begin gap_pct = 16; stall_pct = 16; end
		endcase
	endtask

	function automatic logic [IN_DATA_W-1:0] random_pixel();
		logic [7:0] ch[3];
		foreach (ch[k])
			ch[k] = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
				: 8'($urandom_range(255));
		return {ch[2], ch[1], ch[0]};
	endfunction

	// {blue, green, red}: black, white, primaries, secondaries (V clamp corners), two mid-level values
	logic [IN_DATA_W-1:0] corner_colors[10] = '{
		24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
		24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h800000, 24'h7F807F
	};
	int sweep_width[10] = '{2, 5, 4, 8191, 16, 1, 7, 0, 4096, 6};
	int sweep_height[10] = '{2, 4, 7, 3, 9, 4096, 5, 0, 2, 6};

	initial begin
		int wd;
		int ht;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default frame size straight out of reset
		for (int i = 0; i < 4; i++)
			rgb_backlog.push_back(corner_colors[i]);
		drain();
		// undersized registers fall back to 2x2
		set_size(0, 1);
		for (int i = 0; i < 8; i++)
			rgb_backlog.push_back(corner_colors[(i + 4) % 10]);
		drain();
		// odd size: last column and last row carry no chroma
		set_size(3, 3);
		for (int i = 0; i < 10; i++)
			rgb_backlog.push_back(corner_colors[i]);
		drain();

		for (int p = 0; p < 10; p++) begin
			wd = (p == 7) ? $urandom_range(2, 40) : sweep_width[p];
			ht = (p == 7) ? $urandom_range(2, 12) : sweep_height[p];
			set_size(wd, ht);
			set_idle(p);
			for (int i = $urandom_range(40, 60); i > 0; i--)
				rgb_backlog.push_back(random_pixel());
			drain();
		end

		repeat (8) @(posedge clk);
		$display("%0d pixels over %0d frame sizes, %0d words checked", pixels_in,
			sizes_run + 1, words_out);
		$display("%0d words with chroma, %0d frame ends", chroma_seen, frames_seen);
		if (mismatches == 0)
			$display("rgb_to_yuv420_planar verification clean");
		else
			$display("rgb_to_yuv420_planar verification failed");
		$finish;
	end

endmodule
